// ===== rtl/remt_pkg.sv =====
package remt_pkg;

  // action codes carried by an input item
  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_DELETE = 2'd2
  } remt_action_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } remt_status_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } remt_state_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic cmp;  // capture key compare result
    logic add;  // shift toward the tail, new pair enters at the head
    logic del;  // close the gap at and after the newest match
  } remt_cmd_t;

endpackage

// ===== rtl/remt_cell.sv =====
module remt_cell #(
  parameter int KEY_BITS   = 32,
  parameter int IFACE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  remt_pkg::remt_cmd_t   cmd_i,
  input  logic [KEY_BITS-1:0]   op_key_i,
  // neighbor toward the head (newer)
  input  logic [KEY_BITS-1:0]   prev_key_i,
  input  logic [IFACE_BITS-1:0] prev_iface_i,
  input  logic                  prev_valid_i,
  // neighbor toward the tail (older)
  input  logic [KEY_BITS-1:0]   next_key_i,
  input  logic [IFACE_BITS-1:0] next_iface_i,
  input  logic                  next_valid_i,
  // match seen in any newer cell, and lookup result collected so far
  input  logic                  hit_before_i,
  input  logic [IFACE_BITS-1:0] res_i,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [IFACE_BITS-1:0] iface_o,
  output logic                  valid_o,
  output logic                  hit_after_o,
  output logic [IFACE_BITS-1:0] res_o
);
  import remt_pkg::*;

  logic [KEY_BITS-1:0]   key_q;
  logic [IFACE_BITS-1:0] iface_q;
  logic                  valid_q;
  logic                  match_q;
  logic                  hit;

  // this cell holds the newest match when no newer cell matched
  assign hit         = match_q & ~hit_before_i;
  assign hit_after_o = hit_before_i | match_q;

  // control flops: valid bit and registered compare result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (cmd_i.cmp) begin
        match_q <= valid_q && (key_q == op_key_i);
      end
      if (cmd_i.add) begin
        valid_q <= prev_valid_i;
      end else if (cmd_i.del && hit_after_o) begin
        valid_q <= next_valid_i;
      end
    end
  end

  // payload: shift in from a neighbor
  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      key_q   <= prev_key_i;
      iface_q <= prev_iface_i;
    end else if (cmd_i.del && hit_after_o) begin
      key_q   <= next_key_i;
      iface_q <= next_iface_i;
    end
  end

  assign key_o   = key_q;
  assign iface_o = iface_q;
  assign valid_o = valid_q;
  assign res_o   = res_i | (hit ? iface_q : '0);

endmodule

// ===== rtl/route_exact_match_table_core.sv =====
// each item is captured on input transfer, compared in every cell, then applied
// and its result registered; a new item is taken only in idle, after the apply step,
// which waits while the output register still holds an untaken result
// every cell compares in parallel; the priority pick ripples through the row of cells
// reset clears all valid bits (empty table) and the output valid bit; no clearing pass
module route_exact_match_table_core #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int IFACE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            action_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [IFACE_BITS-1:0] iface_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [IFACE_BITS-1:0] iface_out_o
);
  import remt_pkg::*;

  remt_state_e           state_q, state_d;
  remt_action_e          act_q;
  logic [KEY_BITS-1:0]   op_key_q;
  logic [IFACE_BITS-1:0] op_iface_q;
  logic                  out_valid_q, out_valid_d;
  remt_status_e          status_q, status_d;
  logic [IFACE_BITS-1:0] iface_out_q, iface_out_d;
  remt_cmd_t             cmd;
  logic                  in_xfer;
  logic                  out_free;
  logic                  any_hit;
  logic                  full;
  logic [IFACE_BITS-1:0] lookup_res;

  logic [ENTRIES-1:0][KEY_BITS-1:0]   key_w;
  logic [ENTRIES-1:0][IFACE_BITS-1:0] iface_w;
  logic [ENTRIES-1:0][IFACE_BITS-1:0] res_w;
  logic [ENTRIES-1:0]                 valid_w;
  logic [ENTRIES-1:0]                 hit_w;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // row of cells, cell 0 holds the newest entry
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [KEY_BITS-1:0]   prev_key, next_key;
    logic [IFACE_BITS-1:0] prev_iface, next_iface, res_in;
    logic                  prev_valid, next_valid, hit_in;

    if (i == 0) begin : g_head
      assign prev_key   = op_key_q;
      assign prev_iface = op_iface_q;
      assign prev_valid = 1'b1;
      assign hit_in     = 1'b0;
      assign res_in     = '0;
    end else begin : g_mid
      assign prev_key   = key_w[i-1];
      assign prev_iface = iface_w[i-1];
      assign prev_valid = valid_w[i-1];
      assign hit_in     = hit_w[i-1];
      assign res_in     = res_w[i-1];
    end

    if (i == ENTRIES - 1) begin : g_tail
      assign next_key   = '0;
      assign next_iface = '0;
      assign next_valid = 1'b0;
    end else begin : g_body
      assign next_key   = key_w[i+1];
      assign next_iface = iface_w[i+1];
      assign next_valid = valid_w[i+1];
    end

    remt_cell #(
      .KEY_BITS  (KEY_BITS),
      .IFACE_BITS(IFACE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .op_key_i    (op_key_q),
      .prev_key_i  (prev_key),
      .prev_iface_i(prev_iface),
      .prev_valid_i(prev_valid),
      .next_key_i  (next_key),
      .next_iface_i(next_iface),
      .next_valid_i(next_valid),
      .hit_before_i(hit_in),
      .res_i       (res_in),
      .key_o       (key_w[i]),
      .iface_o     (iface_w[i]),
      .valid_o     (valid_w[i]),
      .hit_after_o (hit_w[i]),
      .res_o       (res_w[i])
    );
  end

  assign any_hit    = hit_w[ENTRIES-1];
  assign full       = valid_w[ENTRIES-1];
  assign lookup_res = res_w[ENTRIES-1];

  // capture the operation on input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q      <= remt_action_e'(action_i);
      op_key_q   <= key_i;
      op_iface_q <= iface_in_i;
    end
  end

  // state and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    iface_out_q <= iface_out_d;
  end

  // sequencer: next state, cell commands and result
  always_comb begin
    state_d     = state_q;
    cmd         = '0;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    iface_out_d = iface_out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.cmp = 1'b1;
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          iface_out_d = '1;
          status_d    = STAT_NOT_FOUND;
          case (act_q)
            ACT_LOOKUP: begin
              if (any_hit) begin
                status_d    = STAT_OK;
                iface_out_d = lookup_res;
              end
            end
            ACT_ADD: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                status_d = STAT_OK;
                cmd.add  = 1'b1;
              end
            end
            ACT_DELETE: begin
              if (any_hit) begin
                status_d = STAT_OK;
                cmd.del  = 1'b1;
              end
            end
            default: begin
              status_d = STAT_NOT_FOUND;
            end
          endcase
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign iface_out_o = iface_out_q;

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import remt_pkg::*;

  localparam int          TABLE_DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam logic [31:0] NO_IFACE    = '1;

  // one expected reply of the route table
  typedef struct packed {
    remt_status_e status;
    logic [31:0]  iface;
  } route_reply_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i    = ACT_LOOKUP;
  logic [31:0] key_i       = '0;
  logic [31:0] iface_in_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] iface_out_o;

  // predicted table contents, newest first
  logic [31:0] route_key[TABLE_DEPTH];
  logic [31:0] route_iface[TABLE_DEPTH];
  int          route_count = 0;

  route_reply_t pending_replies[$];
  int           mismatch_count = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int unsigned  cycle_count    = 0;

  route_exact_match_table_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .key_i       (key_i),
    .iface_in_i  (iface_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .iface_out_o (iface_out_o)
  );

  // clock
  always #2 clk_i = ~clk_i;

  // receiver stalls at random
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // apply one operation to the predicted table and return its reply
  function automatic route_reply_t route_predict(logic [1:0] act, logic [31:0] key,
                                                 logic [31:0] iface);
    route_reply_t reply;
    int           hit;
    reply.status = STAT_NOT_FOUND;
    reply.iface  = NO_IFACE;
    hit = -1;
    for (int i = 0; i < route_count; i++) begin
      if (hit < 0 && route_key[i] == key) hit = i;
    end
    case (act)
      ACT_LOOKUP: begin
        if (hit >= 0) begin
          reply.status = STAT_OK;
          reply.iface  = route_iface[hit];
        end
      end
      ACT_ADD: begin
        if (route_count >= TABLE_DEPTH) begin
          reply.status = STAT_FULL;
        end else begin
          for (int i = route_count; i > 0; i--) begin
            route_key[i]   = route_key[i-1];
            route_iface[i] = route_iface[i-1];
          end
          route_key[0]   = key;
          route_iface[0] = iface;
          route_count++;
          reply.status = STAT_OK;
        end
      end
      ACT_DELETE: begin
        if (hit >= 0) begin
          for (int i = hit; i + 1 < route_count; i++) begin
            route_key[i]   = route_key[i+1];
            route_iface[i] = route_iface[i+1];
          end
          route_count--;
          reply.status = STAT_OK;
        end
      end
      default: ;
    endcase
    return reply;
  endfunction

  // one input transfer, with an optional idle gap in front
  task automatic send_route_op(logic [1:0] act, logic [31:0] key, logic [31:0] iface);
    // each cycle the sender idles with the set chance
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    action_i   <= act;
    key_i      <= key;
    iface_in_i <= iface;
    do @(posedge clk_i); while (in_stall_o);
    pending_replies.push_back(route_predict(act, key, iface));
  endtask

  // compare each result transfer with the oldest expected reply
  always @(posedge clk_i) begin
    route_reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d iface %h", status_o, iface_out_o);
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.status || iface_out_o !== want.iface) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status %0d iface %h, got status %0d iface %h",
                     want.status, want.iface, status_o, iface_out_o);
        end
      end
    end
  end

  // lookup and delete on an empty table miss
  task automatic test_empty_table();
    send_route_op(ACT_LOOKUP, '0, '0);
    send_route_op(ACT_DELETE, '1, '1);
  endtask

  // fill every cell, then one add too many and a lookup of the oldest cell
  task automatic test_fill_and_overflow();
    logic [31:0] key;
    logic [31:0] iface;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 0) begin
        key   = '0;
        iface = '1;
      end else if (i == 1) begin
        key   = '1;
        iface = '0;
      end else begin
        key   = 32'h8000_0000 >> i;
        iface = ~key;
      end
      send_route_op(ACT_ADD, key, iface);
    end
    send_route_op(ACT_ADD, 32'h1234_5678, 32'h8765_4321);
    send_route_op(ACT_LOOKUP, '0, '0);
  endtask

  // duplicate keys: lookup and delete act on the newest copy
  task automatic test_duplicates();
    send_route_op(ACT_DELETE, '1, '0);
    send_route_op(ACT_ADD, '0, 32'hcafe_0001);
    send_route_op(ACT_LOOKUP, '0, '0);
    send_route_op(ACT_DELETE, '0, '0);
    send_route_op(ACT_LOOKUP, '0, '1);
  endtask

  // the unused action code leaves the table alone
  task automatic test_unused_action();
    send_route_op(ACT_UNUSED, '0, '1);
  endtask

  // random traffic over a small key pool so that hits, misses and full are common
  task automatic test_random_traffic(int n_items, int send_pct, int recv_pct);
    logic [31:0] key_pool[8];
    logic [1:0]  act;
    logic [31:0] key;
    int          add_pct;
    int          roll;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    add_pct = 50;
    for (int n = 0; n < n_items; n++) begin
      // new key pool and add rate every segment, so the fill level swings
      if (n % 40 == 0) begin
        foreach (key_pool[k]) begin
          case ($urandom_range(0, 7))
            0:       key_pool[k] = '0;
            1:       key_pool[k] = '1;
            default: key_pool[k] = $urandom;
          endcase
        end
        case ($urandom_range(0, 2))
          0:       add_pct = 15;
          1:       add_pct = 45;
          default: add_pct = 75;
        endcase
      end
      if ($urandom_range(0, 99) < add_pct) begin
        act = ACT_ADD;
      end else begin
        roll = $urandom_range(0, 19);
        if (roll == 0) act = ACT_UNUSED;
        else if (roll < 9) act = ACT_DELETE;
        else act = ACT_LOOKUP;
      end
      key = ($urandom_range(0, 6) != 0) ? key_pool[$urandom_range(0, 7)] : $urandom;
      send_route_op(act, key, $urandom);
    end
  endtask

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // test sequence
  initial begin
    send_idle_pct  = 11;
    recv_stall_pct = 59;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_fill_and_overflow();
    test_duplicates();
    test_unused_action();
    test_random_traffic(483, 11, 59);
    test_random_traffic(483, 59, 11);
    test_random_traffic(484, 0, 0);

    // drain
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/remt_pkg.sv
rtl/remt_cell.sv
rtl/route_exact_match_table_core.sv
dv/tb.sv
